[rtl/alacc_pkg.sv]
// ----------------------------------------------------------------------------
// alacc_pkg
// Shared widths, codes and controller/datapath interface types for the
// autocorrelation lag accumulator.
// ----------------------------------------------------------------------------
package alacc_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int LAG_W    = 6;
    localparam int PROD_W   = 32;
    localparam int SUM_W    = 64;
    localparam int CNT_W    = 32;
    localparam int TOT_W    = 48;

    // stream packing
    localparam int IN_DATA_W  = 24;   // sample + lag, padded to whole bytes
    localparam int OUT_DATA_W = SUM_W + CNT_W + TOT_W + CNT_W;

    // request kinds carried on tuser
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic sample_acc;  // take a sample: ring write, totals, counters
        logic read_acc;    // take a read: launch lag sum read
        logic idx_clr;     // restart the shared index counter
        logic clr_wr;      // clear the lag sum at the index
        logic mac_issue;   // issue one multiply-accumulate at the index
        logic out_load;    // load the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic pass;        // this sample runs an accumulation pass
        logic idx_last;    // index is at its final entry
        logic pipe_busy;   // a MAC is still ahead of its write-back stage
        logic out_free;    // result register can take a new result
    } t_status;

endpackage

[rtl/autocorrelation_lag_accumulator.sv]
// ----------------------------------------------------------------------------
// autocorrelation_lag_accumulator
// Running autocorrelation lag sums over a ring of LAGS samples, with a
// saturating sample sum, sample count and shared pair count.
//
//   channel  dir  fields
//   s_axis   in   tuser: cmd; tdata: sample[15:0], lag[21:16]
//   m_axis   out  tdata: lag_sum, pair_total, sample_total, sample_number
//
// A sample without an accumulation pass leaves the controller idle; with a
// pass the single multiply-accumulate unit steps once per lag through the
// lag sum memory, then drains before the next request. A read waits for the
// result register to be free. After reset a clearing pass zeroes the lag
// sums before the first request is taken. A result waiting on the output
// does not stop samples from being accepted; only the next read waits for it.
// ----------------------------------------------------------------------------
module autocorrelation_lag_accumulator
    import alacc_pkg::*;
#(
    parameter int LAGS = 64
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // sample[15:0], lag[21:16], pad
    input  logic                  i_s_tuser,   // cmd
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata    // lag_sum[63:0], pair_total[95:64],
                                               // sample_total[143:96],
                                               // sample_number[175:144]
);

    t_cmd    cmd;
    t_status status;

    // controller
    alacc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath
    alacc_datapath #(
        .LAGS (LAGS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_sample   (i_s_tdata[SAMPLE_W-1:0]),
        .i_lag      (i_s_tdata[SAMPLE_W+LAG_W-1:SAMPLE_W]),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

[rtl/alacc_ctrl.sv]
// ----------------------------------------------------------------------------
// alacc_ctrl
// Controller: sequences the reset clearing sweep, sample accumulation passes
// and lag reads, and drives the input handshake.
// ----------------------------------------------------------------------------
module alacc_ctrl
    import alacc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    input  logic    i_s_tuser,
    output logic    o_s_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_RD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   n_ready;
    logic   acc;

    assign o_s_tready = r_ready;
    assign acc        = r_ready && i_s_tvalid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.idx_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (acc) begin
                    if (i_s_tuser == CMD_SAMPLE) begin
                        o_cmd.sample_acc = 1'b1;
                        o_cmd.idx_clr    = 1'b1;
                        if (i_status.pass) begin
                            n_state = ST_MAC;
                        end
                    end else begin
                        o_cmd.read_acc = 1'b1;
                        n_state        = ST_RD;
                    end
                end
            end
            ST_MAC: begin
                o_cmd.mac_issue = 1'b1;
                if (i_status.idx_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last write-back lands at the end of this cycle
                if (!i_status.pipe_busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RD: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_ready = (n_state == ST_IDLE);
    end

    // state and registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

endmodule

[rtl/alacc_datapath.sv]
// ----------------------------------------------------------------------------
// alacc_datapath
// Datapath: sample ring, lag sum memory, MAC pipeline with saturation,
// running totals and the result register.
// ----------------------------------------------------------------------------
module alacc_datapath
    import alacc_pkg::*;
#(
    parameter int LAGS = 64
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic [LAG_W-1:0]      i_lag,
    input  logic                  i_m_tready,
    output logic                  o_m_tvalid,
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    localparam int AW = $clog2(LAGS);
    localparam logic [AW-1:0] IDX_LAST = AW'(LAGS - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // memories
    logic signed [SAMPLE_W-1:0] ring [LAGS];
    logic signed [SUM_W-1:0]    lsum [LAGS];

    // control state
    logic [AW-1:0]    r_idx;
    logic [AW-1:0]    r_slot;
    logic [CNT_W-1:0] r_seen;
    logic [CNT_W-1:0] r_pairs;
    logic             r_v1;
    logic             r_v2;
    logic             r_out_valid;

    // payload
    logic signed [SAMPLE_W-1:0] r_vsamp;
    logic [AW-1:0]              r_pslot;   // ring slot of the sample in its pass
    logic signed [TOT_W-1:0]    r_tot;
    logic signed [SAMPLE_W-1:0] r_ring_q;
    logic signed [SUM_W-1:0]    r_ls_q;
    logic signed [SUM_W-1:0]    r_ls_q2;
    logic signed [PROD_W-1:0]   r_prod;
    logic [AW-1:0]              r_d1;
    logic [AW-1:0]              r_d2;
    logic                       r_oob;
    logic [OUT_DATA_W-1:0]      r_out;

    logic [AW-1:0]           d;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           lag_addr;
    logic [31:0]             lag_ext;
    logic                    lag_oob;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic signed [SUM_W-1:0] wr_data;
    logic signed [SUM_W:0]   mac_sum;
    logic signed [SUM_W-1:0] mac_sat;
    logic signed [TOT_W:0]   tot_sum;
    logic signed [TOT_W-1:0] tot_sat;
    logic                    out_free;

    // lag for ring entry idx: (slot - idx) mod LAGS
    always_comb begin
        if (r_pslot >= r_idx) begin
            d = r_pslot - r_idx;
        end else begin
            d = AW'((AW+1)'(r_pslot) + (AW+1)'(LAGS) - (AW+1)'(r_idx));
        end
    end

    // read lag decode
    assign lag_ext  = 32'(i_lag);
    assign lag_oob  = (lag_ext >= 32'(LAGS));
    assign lag_addr = lag_ext[AW-1:0];
    assign rd_addr  = i_cmd.read_acc ? lag_addr : d;

    // saturating accumulate of a product into a lag sum
    always_comb begin
        mac_sum = {r_ls_q2[SUM_W-1], r_ls_q2} + (SUM_W+1)'(r_prod);
        if (mac_sum[SUM_W] != mac_sum[SUM_W-1]) begin
            mac_sat = mac_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                     : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            mac_sat = mac_sum[SUM_W-1:0];
        end
    end

    // saturating running sample sum
    always_comb begin
        tot_sum = {r_tot[TOT_W-1], r_tot} + (TOT_W+1)'(signed'(i_sample));
        if (tot_sum[TOT_W] != tot_sum[TOT_W-1]) begin
            tot_sat = tot_sum[TOT_W] ? {1'b1, {(TOT_W-1){1'b0}}}
                                     : {1'b0, {(TOT_W-1){1'b1}}};
        end else begin
            tot_sat = tot_sum[TOT_W-1:0];
        end
    end

    // lag sum write port: clearing sweep or MAC write-back
    always_comb begin
        wr_en   = i_cmd.clr_wr || r_v2;
        wr_addr = i_cmd.clr_wr ? r_idx : r_d2;
        wr_data = i_cmd.clr_wr ? '0 : mac_sat;
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.sample_acc) begin
            ring[r_slot] <= i_sample;
        end
        if (i_cmd.mac_issue) begin
            r_ring_q <= ring[r_idx];
        end
        if (wr_en) begin
            lsum[wr_addr] <= wr_data;
        end
        if (i_cmd.read_acc || i_cmd.mac_issue) begin
            r_ls_q <= lsum[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_slot      <= '0;
            r_seen      <= '0;
            r_pairs     <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.clr_wr || i_cmd.mac_issue) begin
                r_idx <= (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;
            end
            if (i_cmd.sample_acc && (r_seen != CNT_MAX)) begin
                r_seen <= r_seen + 1'b1;
                r_slot <= (r_slot == IDX_LAST) ? '0 : r_slot + 1'b1;
            end
            if (i_cmd.sample_acc && o_status.pass && (r_pairs != CNT_MAX)) begin
                r_pairs <= r_pairs + 1'b1;
            end
            r_v1 <= i_cmd.mac_issue;
            r_v2 <= r_v1;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // running sum: reset value and saturating update on each sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot <= '0;
        end else if (i_cmd.sample_acc) begin
            r_tot <= tot_sat;
        end
    end

    // pipeline and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.sample_acc) begin
            r_vsamp <= i_sample;
            r_pslot <= r_slot;
        end
        if (i_cmd.read_acc) begin
            r_oob <= lag_oob;
        end
        r_d1    <= d;
        r_d2    <= r_d1;
        r_prod  <= r_vsamp * r_ring_q;
        r_ls_q2 <= r_ls_q;
        if (i_cmd.out_load) begin
            r_out <= {r_seen, r_tot, r_pairs, (r_oob ? {SUM_W{1'b0}} : r_ls_q)};
        end
    end

    assign out_free = !r_out_valid || i_m_tready;

    // status
    assign o_status.pass      = (r_seen > 32'(LAGS));
    assign o_status.idx_last  = (r_idx == IDX_LAST);
    assign o_status.pipe_busy = r_v1;
    assign o_status.out_free  = out_free;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

endmodule
